### src/dotq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dotq_pkg - shared definitions for the deadline ordered timer queue
// Depth, widths, operation and error codes, and the per-cell control group.
// ----------------------------------------------------------------------------
package dotq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int OCC_W       = 5;
	localparam int TIME_W      = 32;
	localparam int IVL_W       = 31;
	localparam int TAG_W       = 8;

	localparam logic [TIME_W-1:0] SIGN32 = 32'h8000_0000;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_PUSH   = 2'd1,
		OP_EXPIRE = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ERR_OK       = 3'd0,
		ERR_FULL     = 3'd1,
		ERR_EMPTY    = 3'd2,
		ERR_NOT_DUE  = 3'd3,
		ERR_ZERO_IVL = 3'd4
	} err_t;

	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctrl_t;

endpackage : dotq_pkg
`default_nettype wire

### src/dotq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dotq_cell - one slot of the sorted timer queue
// Holds one deadline and tag, compares against the incoming key and shifts
// with its neighbours on push and expire.
// ----------------------------------------------------------------------------
module dotq_cell (
	input  wire logic                          clk,
	input  wire dotq_pkg::cell_ctrl_t          ctrl,
	input  wire logic [dotq_pkg::TIME_W-1:0]   now_ms,
	input  wire logic [dotq_pkg::TIME_W-1:0]   key_new,
	input  wire logic [dotq_pkg::TIME_W-1:0]   new_deadline,
	input  wire logic [dotq_pkg::TAG_W-1:0]    new_tag,
	input  wire logic                          occupied,
	input  wire logic                          found_in,
	input  wire logic [dotq_pkg::TIME_W-1:0]   left_deadline,
	input  wire logic [dotq_pkg::TAG_W-1:0]    left_tag,
	input  wire logic [dotq_pkg::TIME_W-1:0]   right_deadline,
	input  wire logic [dotq_pkg::TAG_W-1:0]    right_tag,
	output logic                               found_out,
	output logic [dotq_pkg::TIME_W-1:0]        deadline,
	output logic [dotq_pkg::TAG_W-1:0]         tag
);

	logic [dotq_pkg::TIME_W-1:0] deadline_q;
	logic [dotq_pkg::TAG_W-1:0]  tag_q;
	logic [dotq_pkg::TIME_W-1:0] key;
	logic                        hit;

	// key ordering: unsigned compare of keys equals signed compare of distances
	assign key       = (deadline_q - now_ms) ^ dotq_pkg::SIGN32;
	assign hit       = !occupied || (key > key_new);
	assign found_out = found_in || hit;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			if (found_in) begin
				deadline_q <= left_deadline;
				tag_q      <= left_tag;
			end else if (hit) begin
				deadline_q <= new_deadline;
				tag_q      <= new_tag;
			end
		end else if (ctrl.pop) begin
			deadline_q <= right_deadline;
			tag_q      <= right_tag;
		end
	end

	assign deadline = deadline_q;
	assign tag      = tag_q;

endmodule : dotq_cell
`default_nettype wire

### src/deadline_ordered_timer_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_ordered_timer_queue - bounded timer queue kept in deadline order
// Millisecond clock, sorted row of cells, push / expire / tick handling and
// a registered result stage.
// ----------------------------------------------------------------------------
// Each item is tick (advance the clock by one), push (store a tag due at now
// plus the interval, after every entry not due later) or expire (remove the
// head, return its tag if due). The queue is a row of QUEUE_DEPTH cells,
// cell 0 the head; every cell compares its own deadline with the incoming one
// at once and a found flag ripples along the row to pick the insertion slot,
// so a push, expire or tick updates the whole queue together. The result
// of an item is formed after it is taken, once the output register is
// free, from the updated state, and held in an output register. The block
// takes one item per cycle while the output side keeps up. The cycle time
// is set by the per-cell 32-bit subtract and compare plus the found-flag
// ripple through all QUEUE_DEPTH cells. The deadline and tag cells are not
// reset; only occupied cells are ever read.
// ----------------------------------------------------------------------------
module deadline_ordered_timer_queue (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input channel
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [1:0]                          opcode,
	input  wire logic [dotq_pkg::TAG_W-1:0]          event_tag,
	input  wire logic [dotq_pkg::IVL_W-1:0]          interval_ms,
	// result channel
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     tag_valid,
	output logic [dotq_pkg::TAG_W-1:0]               out_tag,
	output logic [2:0]                               error_code,
	output logic [dotq_pkg::IVL_W-1:0]               wait_ms,
	output logic [dotq_pkg::OCC_W-1:0]               occupancy
);

	localparam int N = dotq_pkg::QUEUE_DEPTH;

	// control state
	logic [dotq_pkg::TIME_W-1:0] now_q;
	logic [dotq_pkg::CNT_W-1:0]  count_q;
	logic                        pend_q;
	logic                        out_valid_q;

	// item result waiting for its status fields
	logic                        tag_valid_s1;
	logic [dotq_pkg::TAG_W-1:0]  tag_s1;
	dotq_pkg::err_t              err_s1;

	// output register
	logic                        tag_valid_q;
	logic [dotq_pkg::TAG_W-1:0]  tag_q;
	dotq_pkg::err_t              err_q;
	logic [dotq_pkg::IVL_W-1:0]  wait_q;
	logic [dotq_pkg::OCC_W-1:0]  occ_q;

	// cell row
	logic [dotq_pkg::TIME_W-1:0] cell_deadline [N];
	logic [dotq_pkg::TAG_W-1:0]  cell_tag      [N];
	logic                        found         [N];
	logic [N-1:0]                occupied;
	dotq_pkg::cell_ctrl_t        ctrl;

	logic                        in_fire;
	logic                        out_free;
	logic                        full;
	logic                        empty;
	logic [dotq_pkg::TIME_W-1:0] head_dist;
	logic                        head_due;
	logic [dotq_pkg::TIME_W-1:0] key_new;
	logic [dotq_pkg::TIME_W-1:0] new_deadline;

	// next-state of the item decode
	logic [dotq_pkg::TIME_W-1:0] now_d;
	logic [dotq_pkg::CNT_W-1:0]  count_d;
	logic                        tag_valid_d;
	logic [dotq_pkg::TAG_W-1:0]  tag_d;
	dotq_pkg::err_t              err_d;

	// handshake: the result stage parts the two sides
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = pend_q && !out_free;
	assign in_fire  = in_valid && !in_stall;

	assign full  = (count_q == dotq_pkg::CNT_W'(N));
	assign empty = (count_q == '0);

	// head status against the current clock
	assign head_dist = cell_deadline[0] - now_q;
	assign head_due  = (head_dist == '0) || head_dist[dotq_pkg::TIME_W-1];

	// new entry: distance equals the interval, sign bit of the key is set
	assign key_new      = {1'b1, interval_ms};
	assign new_deadline = now_q + {1'b0, interval_ms};

	// decode the item
	always_comb begin
		now_d       = now_q;
		count_d     = count_q;
		tag_valid_d = 1'b0;
		tag_d       = '0;
		err_d       = dotq_pkg::ERR_OK;
		ctrl        = '0;
		unique case (dotq_pkg::op_t'(opcode))
			dotq_pkg::OP_TICK: begin
				now_d = now_q + 1'b1;
			end
			dotq_pkg::OP_PUSH: begin
				if (full) begin
					err_d = dotq_pkg::ERR_FULL;
				end else if (interval_ms == '0) begin
					err_d = dotq_pkg::ERR_ZERO_IVL;
				end else begin
					ctrl.push = in_fire;
					count_d   = count_q + 1'b1;
				end
			end
			dotq_pkg::OP_EXPIRE: begin
				if (empty) begin
					err_d = dotq_pkg::ERR_EMPTY;
				end else begin
					ctrl.pop = in_fire;
					count_d  = count_q - 1'b1;
					if (head_due) begin
						tag_valid_d = 1'b1;
						tag_d       = cell_tag[0];
					end else begin
						err_d = dotq_pkg::ERR_NOT_DUE;
					end
				end
			end
			default: begin
				// unused opcode: no operation, status only
			end
		endcase
	end

	// the cell row; cell 0 is the head
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic                        found_left;
		logic [dotq_pkg::TIME_W-1:0] left_dl;
		logic [dotq_pkg::TAG_W-1:0]  left_tg;
		logic [dotq_pkg::TIME_W-1:0] right_dl;
		logic [dotq_pkg::TAG_W-1:0]  right_tg;

		assign occupied[i] = (dotq_pkg::CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			// nothing to the left of the head: hand in the new entry
			assign found_left = 1'b0;
			assign left_dl    = new_deadline;
			assign left_tg    = event_tag;
		end else begin : g_body
			assign found_left = found[i-1];
			assign left_dl    = cell_deadline[i-1];
			assign left_tg    = cell_tag[i-1];
		end

		if (i == N - 1) begin : g_tail
			// the tail holds its own contents on expire
			assign right_dl = cell_deadline[i];
			assign right_tg = cell_tag[i];
		end else begin : g_inner
			assign right_dl = cell_deadline[i+1];
			assign right_tg = cell_tag[i+1];
		end

		dotq_cell u_cell (
			.clk            (clk),
			.ctrl           (ctrl),
			.now_ms         (now_q),
			.key_new        (key_new),
			.new_deadline   (new_deadline),
			.new_tag        (event_tag),
			.occupied       (occupied[i]),
			.found_in       (found_left),
			.left_deadline  (left_dl),
			.left_tag       (left_tg),
			.right_deadline (right_dl),
			.right_tag      (right_tg),
			.found_out      (found[i]),
			.deadline       (cell_deadline[i]),
			.tag            (cell_tag[i])
		);
	end

	// clock, occupancy and the pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q   <= '0;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			if (in_fire) begin
				now_q   <= now_d;
				count_q <= count_d;
				pend_q  <= 1'b1;
			end else if (out_free) begin
				pend_q  <= 1'b0;
			end
		end
	end

	// hold the item's own fields until the status is formed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			tag_valid_s1 <= tag_valid_d;
			tag_s1       <= tag_d;
			err_s1       <= err_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_q && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// form the result from the updated state
	always_ff @(posedge clk) begin
		if (pend_q && out_free) begin
			tag_valid_q <= tag_valid_s1;
			tag_q       <= tag_s1;
			err_q       <= err_s1;
			wait_q      <= (empty || head_due) ? '0 : head_dist[dotq_pkg::IVL_W-1:0];
			occ_q       <= dotq_pkg::OCC_W'(count_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign tag_valid  = tag_valid_q;
	assign out_tag    = tag_q;
	assign error_code = err_q;
	assign wait_ms    = wait_q;
	assign occupancy  = occ_q;

	// an accepted push always finds a slot somewhere in the row
	a_push_finds_slot : assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |-> found[N-1])
		else $error("push found no insertion slot");

	// occupancy never exceeds the queue depth
	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dotq_pkg::CNT_W'(N))
		else $error("entry count beyond queue depth");

	// a returned tag always comes with no error
	a_tag_ok : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tag_valid |-> error_code == dotq_pkg::ERR_OK)
		else $error("returned tag with an error code");

	// a rejected push on a full queue leaves the queue full
	a_full_occ : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_code == dotq_pkg::ERR_FULL)
			|-> occupancy == dotq_pkg::OCC_W'(N))
		else $error("full error without a full queue");

endmodule : deadline_ordered_timer_queue
`default_nettype wire
